// ===== rtl/sobel_gradient_fixed_point_unit_macros.svh =====
// Assertion macros for the Sobel gradient unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SOBEL_GRADIENT_FIXED_POINT_UNIT_MACROS_SVH
`define SOBEL_GRADIENT_FIXED_POINT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SGF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sobel gradient check failed");
`define SGF_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sobel gradient forbidden condition");
`else
`define SGF_ASSERT(lbl, clk, rstn, prop)
`define SGF_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/sobgrad_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Sobel gradient unit.
// No dependencies.
`default_nettype none

package sobgrad_pkg;

  localparam int SAMPLE_BITS  = 8;
  localparam int MAX_COLS     = 256;
  localparam int MAX_ROWS     = 256;
  localparam int IN_INT_BITS  = 1;
  localparam int OUT_INT_BITS = 4;
  localparam int ALIGN_SHIFT  = OUT_INT_BITS - IN_INT_BITS;

  localparam int SizeW  = 9;
  localparam int OutW   = 8;
  localparam int ColW   = $clog2(MAX_COLS);
  localparam int RowW   = $clog2(MAX_ROWS + 2);
  localparam int AccW   = SAMPLE_BITS + ALIGN_SHIFT + 2;
  localparam int HalfLsb = 1 << (ALIGN_SHIFT - 1);
  localparam int SatMax  = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SatMin  = -(1 << (SAMPLE_BITS - 1));

  localparam logic [SizeW-1:0] SIZE_RESET = SizeW'(150);
  localparam logic [SizeW-1:0] SIZE_MIN   = SizeW'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [2:0]             coef_t;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  localparam coef_t COEF_X [9] = '{3'sd1, 3'sd0, -3'sd1,
                                   3'sd2, 3'sd0, -3'sd2,
                                   3'sd1, 3'sd0, -3'sd1};
  localparam coef_t COEF_Y [9] = '{3'sd1,  3'sd2,  3'sd1,
                                   3'sd0,  3'sd0,  3'sd0,
                                   -3'sd1, -3'sd2, -3'sd1};

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v,
                                                  logic [SizeW-1:0] hi);
    logic [SizeW-1:0] r;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // acc*2^shift + v*c, round to nearest (ties up), saturate
  function automatic sample_t add_tap(sample_t acc, sample_t v, coef_t c);
    logic signed [AccW-1:0] s;
    logic signed [AccW-1:0] q;
    sample_t r;
    s = (AccW'(acc) <<< ALIGN_SHIFT) + AccW'(v) * AccW'(c);
    q = (s + AccW'(HalfLsb)) >>> ALIGN_SHIFT;
    if (q > AccW'(SatMax)) begin
      r = sample_t'(SatMax);
    end else if (q < AccW'(SatMin)) begin
      r = sample_t'(SatMin);
    end else begin
      r = q[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sobel_gradient_fixed_point_unit.sv =====
// Top level of the streaming 3x3 Sobel gradient unit.
// Depends on sobgrad_pkg, sobgrad_ram and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request per cycle while
//   ready: a pixel sample in raster order, or a drain request after the frame.
//   After rows*cols pixels send cols+1 drain requests to flush the last outputs.
//   Output channel (out_valid_o/out_ready_i) gives zero or one gradient per
//   request: grad_x/grad_y in Q4.4 with row, column and a frame_last flag.
//   Gradient (i,j) leaves with the request for pixel (i+1,j+1), or for the
//   next row's column 0 at the right edge.
//   Throughput: one request per cycle unless the output stalls, set by the
//   column line store RAM (one read and one write per cycle) and a
//   four-register pipeline: request, tap, first-half and result registers.
//   Requests that produce no result drop out after the window stage, so the
//   input keeps flowing while a stalled output holds, until the pipeline
//   behind it fills; then in_ready_o falls.
//   Reset: sizes 150x150, scan at row 0 column 0, window cleared. Line
//   store contents are unknown; rows outside the image are masked.
//   A configuration write restarts the frame; write only when idle.
`default_nettype none
`include "sobel_gradient_fixed_point_unit_macros.svh"

module sobel_gradient_fixed_point_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [sobgrad_pkg::SizeW-1:0]       cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic                                operation_i,
  input  wire logic signed [sobgrad_pkg::SAMPLE_BITS-1:0] pixel_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [sobgrad_pkg::SAMPLE_BITS-1:0] grad_x_o,
  output      logic signed [sobgrad_pkg::SAMPLE_BITS-1:0] grad_y_o,
  output      logic [sobgrad_pkg::OutW-1:0]        out_row_o,
  output      logic [sobgrad_pkg::OutW-1:0]        out_col_o,
  output      logic                                frame_last_o
);

  import sobgrad_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] orow;
    logic [OutW-1:0] ocol;
    logic            last;
  } meta_t;

  typedef struct packed {
    sample_t         sample;
    logic [ColW-1:0] addr;
    logic            col_zero;
    logic            top_ok;
    logic            mid_ok;
    logic            res;
    meta_t           meta;
  } s1_t;

  // configuration
  logic [SizeW-1:0] rows_q, cols_q;
  logic [SizeW-1:0] rows_eff, cols_eff, cols_m1;
  logic [SizeW:0]   rows_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS: rows_q <= cfg_wdata_i;
        CFG_COLS: cols_q <= cfg_wdata_i;
        default:  rows_q <= rows_q;
      endcase
    end
  end

  assign rows_eff = clamp_size(rows_q, SizeW'(MAX_ROWS));
  assign cols_eff = clamp_size(cols_q, SizeW'(MAX_COLS));
  assign cols_m1  = cols_eff - SizeW'(1);
  assign rows_lim = {1'b0, rows_eff} + (SizeW+1)'(1);

  // pipeline handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4, move1, accept;
  s1_t  s1_q, s1_d;

  assign ld4    = !v4_q || out_ready_i;
  assign ld3    = !v3_q || ld4;
  assign ld2    = !v2_q || ld3;
  assign move1  = v1_q && (ld2 || !s1_q.res);
  assign ld1    = !v1_q || move1;
  assign accept = in_valid_i && ld1;
  assign in_ready_o = ld1;

  // scan position and request decode
  logic [RowW-1:0] row_q, row_d, r_m1, r_m2;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW:0]   c_inc;

  always_comb begin
    r_m1  = row_q - RowW'(1);
    r_m2  = row_q - RowW'(2);
    c_inc = {1'b0, col_q} + (ColW+1)'(1);

    s1_d.sample   = (op_e'(operation_i) == OP_PIXEL && row_q < rows_eff) ? pixel_i : '0;
    s1_d.addr     = col_q;
    s1_d.col_zero = (col_q == '0);
    s1_d.top_ok   = (row_q >= RowW'(2)) && (r_m2 < rows_eff);
    s1_d.mid_ok   = (row_q >= RowW'(1)) && (r_m1 < rows_eff);
    s1_d.res      = s1_d.col_zero ? s1_d.top_ok : s1_d.mid_ok;
    s1_d.meta.orow = s1_d.col_zero ? OutW'(r_m2) : OutW'(r_m1);
    s1_d.meta.ocol = s1_d.col_zero ? OutW'(cols_m1) : OutW'(col_q - ColW'(1));
    s1_d.meta.last = s1_d.col_zero && s1_d.top_ok && (r_m2 == rows_eff - SizeW'(1));

    priority if ({1'b0, row_q} >= rows_lim) begin
      row_d = '0;
      col_d = '0;
    end else if (c_inc >= cols_eff) begin
      row_d = row_q + RowW'(1);
      col_d = '0;
    end else begin
      row_d = row_q;
      col_d = c_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // line stores: upper byte is two rows back, lower byte one row back
  logic [2*SAMPLE_BITS-1:0] ls_rdata;
  sample_t                  rd_upper, rd_lower;

  assign rd_upper = ls_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign rd_lower = ls_rdata[SAMPLE_BITS-1:0];

  sobgrad_ram #(
    .Width(2 * SAMPLE_BITS),
    .Depth(MAX_COLS)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (move1),
    .waddr_i(s1_q.addr),
    .wdata_i({rd_lower, s1_q.sample}),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(ls_rdata)
  );

  // window stage
  sample_t win_q [9];
  sample_t win_d [9];
  sample_t taps  [9];
  sample_t new_col [3];

  always_comb begin
    new_col[0] = s1_q.top_ok ? rd_upper : '0;
    new_col[1] = s1_q.mid_ok ? rd_lower : '0;
    new_col[2] = s1_q.sample;
    for (int k = 0; k < 3; k++) begin
      taps[3*k]     = win_q[3*k+1];
      taps[3*k+1]   = win_q[3*k+2];
      taps[3*k+2]   = s1_q.col_zero ? '0 : new_col[k];
      win_d[3*k]    = s1_q.col_zero ? '0 : taps[3*k];
      win_d[3*k+1]  = s1_q.col_zero ? '0 : taps[3*k+1];
      win_d[3*k+2]  = new_col[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (move1) begin
      win_q <= win_d;
    end
  end

  // tap register
  sample_t tap2_q [9];
  meta_t   meta2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= v1_q && s1_q.res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q && s1_q.res) begin
      tap2_q  <= taps;
      meta2_q <= s1_q.meta;
    end
  end

  // first half of the tap chain
  sample_t gx_p, gy_p;
  sample_t gx3_q, gy3_q;
  sample_t tail3_q [4];
  meta_t   meta3_q;

  always_comb begin
    gy_p = add_tap(add_tap(add_tap('0, tap2_q[0], COEF_Y[0]),
                           tap2_q[1], COEF_Y[1]), tap2_q[2], COEF_Y[2]);
    gx_p = add_tap(add_tap(add_tap('0, tap2_q[0], COEF_X[0]),
                           tap2_q[2], COEF_X[2]), tap2_q[3], COEF_X[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ld3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3 && v2_q) begin
      gx3_q   <= gx_p;
      gy3_q   <= gy_p;
      meta3_q <= meta2_q;
      for (int k = 0; k < 4; k++) begin
        tail3_q[k] <= tap2_q[k+5];
      end
    end
  end

  // second half and result register
  sample_t gx_f, gy_f;
  sample_t gx4_q, gy4_q;
  meta_t   meta4_q;

  always_comb begin
    gy_f = add_tap(add_tap(add_tap(gy3_q, tail3_q[1], COEF_Y[6]),
                           tail3_q[2], COEF_Y[7]), tail3_q[3], COEF_Y[8]);
    gx_f = add_tap(add_tap(add_tap(gx3_q, tail3_q[0], COEF_X[5]),
                           tail3_q[1], COEF_X[6]), tail3_q[3], COEF_X[8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ld4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4 && v3_q) begin
      gx4_q   <= gx_f;
      gy4_q   <= gy_f;
      meta4_q <= meta3_q;
    end
  end

  assign out_valid_o  = v4_q;
  assign grad_x_o     = gx4_q;
  assign grad_y_o     = gy4_q;
  assign out_row_o    = meta4_q.orow;
  assign out_col_o    = meta4_q.ocol;
  assign frame_last_o = meta4_q.last;

  `SGF_ASSERT(a_col_in_frame, clk_i, rst_ni, col_q < cols_eff)
  `SGF_ASSERT(a_row_in_scan, clk_i, rst_ni, row_q <= rows_lim)
  `SGF_ASSERT(a_last_at_edge, clk_i, rst_ni, (out_valid_o && frame_last_o) |-> (out_col_o == OutW'(cols_m1)))
  `SGF_NEVER(a_result_lost, clk_i, rst_ni, v1_q && s1_q.res && move1 && !ld2)

endmodule

`default_nettype wire

// ===== rtl/sobgrad_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies.
`default_nettype none

module sobgrad_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
